>>> rtl/fisr_pkg.sv
// shared constants, types and rounding helpers for the fast inverse square root block
// no dependencies; used by fisr_fmul, fisr_fadd and fast_inverse_square_root
`timescale 1ns / 1ps

package fisr_pkg;

	localparam logic [31:0] MAGIC_GUESS       = 32'h5f3759df;
	localparam logic [31:0] CANON_NAN         = 32'h7fc00000;
	localparam logic [31:0] HALF_BITS         = 32'h3f000000;
	localparam logic [31:0] THREE_HALVES_BITS = 32'h3fc00000;
	localparam logic [7:0]  EXP_ALL_ONES      = 8'hff;

	// request codes
	localparam logic REQ_INV_SQRT = 1'b0;
	localparam logic REQ_SQRT     = 1'b1;

	// biased exponent with headroom for under and overflow
	typedef logic signed [10:0] exp_t;

	localparam exp_t EXP_MAX = 11'sd255;

	// biased must be at least one; subnormals come in with biased one and hidden bit clear
	function automatic logic [31:0] fp_round(input logic sign, input exp_t biased,
			input logic [23:0] mant, input logic guard, input logic sticky);
		logic        up;
		logic [30:0] mag;
		logic [7:0]  ebits;
		up    = guard & (sticky | mant[0]);
		ebits = biased[7:0] - 8'd1;
		mag   = {ebits, 23'd0} + {7'd0, mant} + {30'd0, up};
		if (biased >= EXP_MAX) begin
			return {sign, EXP_ALL_ONES, 23'd0};
		end
		return {sign, mag};
	endfunction

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == EXP_ALL_ONES) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return (v[30:23] == EXP_ALL_ONES) && (v[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	// significand with hidden bit, subnormals read with exponent one
	function automatic logic [23:0] sig_of(input logic [31:0] v);
		return {(v[30:23] != 8'd0), v[22:0]};
	endfunction

	function automatic logic [7:0] exp_of(input logic [31:0] v);
		return (v[30:23] == 8'd0) ? 8'd1 : v[30:23];
	endfunction

	function automatic logic [31:0] canon(input logic [31:0] v);
		return is_nan(v) ? CANON_NAN : v;
	endfunction

endpackage

>>> rtl/fisr_fmul.sv
// three stage binary32 multiplier, round to nearest even, full subnormal support
// depends on fisr_pkg; carries a sideband word alongside each item
`timescale 1ns / 1ps

module fisr_fmul #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [31:0]       p,
	output logic [SIDE_W-1:0] side_o
);

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n     = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	logic              vld_s1, vld_s2, vld_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic              sign_s1, nan_s1, inf_s1, zero_s1;
	logic              sign_s2, nan_s2, inf_s2, zero_s2;
	logic [47:0]       prod_s1, norm_s2;
	fisr_pkg::exp_t    exp_s1, exp_s2;
	logic [31:0]       p_s3;

	// stage 1 operands
	logic           a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	fisr_pkg::exp_t esum;

	// stage 3 rounding inputs
	fisr_pkg::exp_t sh_full, be;
	logic [5:0]     sh;
	logic [47:0]    shifted;
	logic           lost;
	logic [23:0]    mant;
	logic           grd, stk;
	logic [31:0]    res;

	always_comb begin
		a_nan  = fisr_pkg::is_nan(a);
		b_nan  = fisr_pkg::is_nan(b);
		a_inf  = fisr_pkg::is_inf(a);
		b_inf  = fisr_pkg::is_inf(b);
		a_zero = fisr_pkg::is_zero(a);
		b_zero = fisr_pkg::is_zero(b);
		esum   = fisr_pkg::exp_t'({3'd0, fisr_pkg::exp_of(a)})
			+ fisr_pkg::exp_t'({3'd0, fisr_pkg::exp_of(b)}) - 11'sd126;
	end

	always_comb begin
		sh_full = 11'sd1 - exp_s2;
		sh      = (sh_full > 11'sd63) ? 6'd63 : sh_full[5:0];
		shifted = norm_s2 >> sh;
		lost    = |(norm_s2 & ~({48{1'b1}} << sh));
		if (exp_s2 >= 11'sd1) begin
			mant = norm_s2[47:24];
			grd  = norm_s2[23];
			stk  = |norm_s2[22:0];
			be   = exp_s2;
		end else begin
			mant = shifted[47:24];
			grd  = shifted[23];
			stk  = (|shifted[22:0]) | lost;
			be   = 11'sd1;
		end
		if (nan_s2) begin
			res = fisr_pkg::CANON_NAN;
		end else if (inf_s2) begin
			res = {sign_s2, fisr_pkg::EXP_ALL_ONES, 23'd0};
		end else if (zero_s2) begin
			res = {sign_s2, 31'd0};
		end else begin
			res = fisr_pkg::fp_round(sign_s2, be, mant, grd, stk);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_i;
			sign_s1 <= a[31] ^ b[31];
			nan_s1  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
			inf_s1  <= a_inf | b_inf;
			zero_s1 <= a_zero | b_zero;
			prod_s1 <= fisr_pkg::sig_of(a) * fisr_pkg::sig_of(b);
			exp_s1  <= esum;

			side_s2 <= side_s1;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
			norm_s2 <= prod_s1 << lzc48(prod_s1);
			exp_s2  <= exp_s1 - fisr_pkg::exp_t'({5'd0, lzc48(prod_s1)});

			side_s3 <= side_s2;
			p_s3    <= res;
		end
	end

	assign vld_o  = vld_s3;
	assign p      = p_s3;
	assign side_o = side_s3;

endmodule

>>> rtl/fisr_fadd.sv
// three stage binary32 adder, round to nearest even, full subnormal support
// depends on fisr_pkg; carries a sideband word alongside each item
`timescale 1ns / 1ps

module fisr_fadd #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [SIDE_W-1:0] side_i,
	output logic              vld_o,
	output logic [31:0]       s,
	output logic [SIDE_W-1:0] side_o
);

	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		logic       found;
		n     = 5'd28;
		found = 1'b0;
		for (int i = 27; i >= 0; i--) begin
			if (!found && v[i]) begin
				n     = 5'(27 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	logic              vld_s1, vld_s2, vld_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic              sign_s1, sub_s1, zsign_s1, nan_s1, inf_s1, isign_s1;
	logic              sign_s2, zsign_s2, nan_s2, inf_s2, isign_s2, zero_s2;
	logic [26:0]       big_s1, al_s1;
	logic [7:0]        exp_s1;
	logic [27:0]       norm_s2;
	fisr_pkg::exp_t    be_s2;
	logic [31:0]       s_s3;

	// stage 1 swap and align
	logic        swap;
	logic [31:0] op_big, op_sml;
	logic [7:0]  diff;
	logic [4:0]  ash;
	logic [26:0] sml_ext, al;
	logic        a_inf, b_inf;

	// stage 2 add and normalize
	logic [27:0] sum;
	logic [4:0]  lz, lz_eff;

	logic [31:0] res;

	always_comb begin
		swap    = b[30:0] > a[30:0];
		op_big  = swap ? b : a;
		op_sml  = swap ? a : b;
		diff    = fisr_pkg::exp_of(op_big) - fisr_pkg::exp_of(op_sml);
		ash     = (diff > 8'd27) ? 5'd27 : diff[4:0];
		sml_ext = {fisr_pkg::sig_of(op_sml), 3'b000};
		al      = (sml_ext >> ash) | {26'd0, |(sml_ext & ~({27{1'b1}} << ash))};
		a_inf   = fisr_pkg::is_inf(a);
		b_inf   = fisr_pkg::is_inf(b);
	end

	always_comb begin
		sum    = sub_s1 ? ({1'b0, big_s1} - {1'b0, al_s1}) : ({1'b0, big_s1} + {1'b0, al_s1});
		lz     = lzc28(sum);
		lz_eff = ({3'd0, lz} > exp_s1) ? exp_s1[4:0] : lz;
	end

	always_comb begin
		if (nan_s2) begin
			res = fisr_pkg::CANON_NAN;
		end else if (inf_s2) begin
			res = {isign_s2, fisr_pkg::EXP_ALL_ONES, 23'd0};
		end else if (zero_s2) begin
			res = {zsign_s2, 31'd0};
		end else begin
			res = fisr_pkg::fp_round(sign_s2, be_s2, norm_s2[27:4], norm_s2[3], |norm_s2[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_i;
			sign_s1  <= op_big[31];
			sub_s1   <= a[31] ^ b[31];
			zsign_s1 <= a[31] & b[31];
			nan_s1   <= fisr_pkg::is_nan(a) | fisr_pkg::is_nan(b)
				| (a_inf & b_inf & (a[31] ^ b[31]));
			inf_s1   <= a_inf | b_inf;
			isign_s1 <= a_inf ? a[31] : b[31];
			big_s1   <= {fisr_pkg::sig_of(op_big), 3'b000};
			al_s1    <= al;
			exp_s1   <= fisr_pkg::exp_of(op_big);

			side_s2  <= side_s1;
			sign_s2  <= sign_s1;
			zsign_s2 <= zsign_s1;
			nan_s2   <= nan_s1;
			inf_s2   <= inf_s1;
			isign_s2 <= isign_s1;
			zero_s2  <= sum == 28'd0;
			norm_s2  <= sum << lz_eff;
			be_s2    <= fisr_pkg::exp_t'({3'd0, exp_s1}) + 11'sd1
				- fisr_pkg::exp_t'({6'd0, lz_eff});

			side_s3  <= side_s2;
			s_s3     <= res;
		end
	end

	assign vld_o  = vld_s3;
	assign s      = s_s3;
	assign side_o = side_s3;

endmodule

>>> rtl/fast_inverse_square_root.sv
// top level: magic-constant guess, one newton step, optional multiply by the operand
// depends on fisr_pkg, fisr_fmul and fisr_fadd
`timescale 1ns / 1ps

// fast inverse square root, one newton step, fully pipelined.
// one item in per cycle while in_stall is low, one result out per item, in order.
// the pipe is five three-stage multipliers and one three-stage adder in a chain
// (x*0.5, h*y0, t*y0, 1.5-t, y0*d, y*x) plus the output register.
// the guess y0 is 0x5f3759df minus the operand pattern shifted right by one,
// with the sign bit kept. every float step rounds to nearest even and handles
// subnormals, infinities and zeros as ieee binary32 does; any nan answer comes
// out as the quiet nan 0x7fc00000. req_type 0 returns y, req_type 1 returns y*x.
// the whole pipe advances together: while a result sits in the output register
// with out_stall high, every stage holds and in_stall is raised; an empty output
// register or a taken result lets the pipe, and a new item, move on the same cycle.

module fast_inverse_square_root (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] operand_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_bits
);

	// sideband through the first five units: request, operand, guess
	localparam int SIDE_W = 65;
	// sideband through the last unit: request and inverse root
	localparam int LAST_W = 33;

	logic        en;
	logic [31:0] guess;

	logic              h_vld, t1_vld, t_vld, d_vld, y_vld, r_vld;
	logic [31:0]       h, t1, t, d, y, r;
	logic [SIDE_W-1:0] h_side, t1_side, t_side, d_side, y_side;
	logic [LAST_W-1:0] r_side;

	logic        out_valid_q;
	logic [31:0] res_q;
	logic        fin_req;
	logic [31:0] fin_y;

	// whole pipe moves unless a finished item waits to be taken
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	// magic-constant first guess, arithmetic shift keeps the sign bit
	assign guess = fisr_pkg::MAGIC_GUESS - {operand_bits[31], operand_bits[31:1]};

	// h = x * 0.5
	fisr_fmul #(.SIDE_W(SIDE_W)) u_half (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(in_valid), .a(operand_bits), .b(fisr_pkg::HALF_BITS),
		.side_i({req_type, operand_bits, guess}),
		.vld_o(h_vld), .p(h), .side_o(h_side)
	);

	// t1 = h * y0
	fisr_fmul #(.SIDE_W(SIDE_W)) u_hy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(h_vld), .a(h), .b(h_side[31:0]), .side_i(h_side),
		.vld_o(t1_vld), .p(t1), .side_o(t1_side)
	);

	// t = t1 * y0
	fisr_fmul #(.SIDE_W(SIDE_W)) u_hyy (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(t1_vld), .a(t1), .b(t1_side[31:0]), .side_i(t1_side),
		.vld_o(t_vld), .p(t), .side_o(t_side)
	);

	// d = 1.5 - t, done as 1.5 + (-t)
	fisr_fadd #(.SIDE_W(SIDE_W)) u_diff (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(t_vld), .a(fisr_pkg::THREE_HALVES_BITS), .b({~t[31], t[30:0]}),
		.side_i(t_side),
		.vld_o(d_vld), .s(d), .side_o(d_side)
	);

	// y = y0 * d
	fisr_fmul #(.SIDE_W(SIDE_W)) u_refine (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(d_vld), .a(d_side[31:0]), .b(d), .side_i(d_side),
		.vld_o(y_vld), .p(y), .side_o(y_side)
	);

	// r = y * x, used only for root requests
	fisr_fmul #(.SIDE_W(LAST_W)) u_root (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vld_i(y_vld), .a(y), .b(y_side[63:32]), .side_i({y_side[64], y}),
		.vld_o(r_vld), .p(r), .side_o(r_side)
	);

	assign fin_req = r_side[32];
	assign fin_y   = r_side[31:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= fisr_pkg::canon((fin_req == fisr_pkg::REQ_SQRT) ? r : fin_y);
		end
	end

	assign out_valid   = out_valid_q;
	assign result_bits = res_q;

	// a delivered nan always carries the canonical pattern
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_bits[30:23] == fisr_pkg::EXP_ALL_ONES)
			&& (result_bits[22:0] != 23'd0)) |-> (result_bits == fisr_pkg::CANON_NAN))
		else $error("non-canonical nan delivered");

	// with no waiting result the pipe never pushes back on the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	// a held result keeps its value until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(result_bits)))
		else $error("stalled result lost or changed");

endmodule
